[hdl/serial_rgb_led_strip_frame_engine_macros.svh]
`ifndef SERIAL_RGB_LED_STRIP_FRAME_ENGINE_MACROS_SVH
`define SERIAL_RGB_LED_STRIP_FRAME_ENGINE_MACROS_SVH

// property checked at every edge outside reset
`define SRGB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// consequence checked after the trigger, as a non-overlapping implication
`define SRGB_ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

[hdl/srgb_pkg.sv]
package srgb_pkg;

    localparam int MAX_LEDS      = 256;
    localparam int LED_AW        = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

    localparam int CMD_W         = 2;
    localparam int IDX_W         = 8;
    localparam int CHAN_W        = 8;
    localparam int COLOUR_W      = 3 * CHAN_W;
    localparam int BYTE_W        = 8;
    localparam int COUNT_W       = 9;
    localparam int BRIGHT_W      = 5;

    localparam int START_BYTES   = 4;
    localparam int BYTES_PER_LED = 4;
    localparam int END_GROUP     = 16;
    localparam int END_SHIFT     = $clog2(END_GROUP);
    localparam int MAX_TOTAL     = START_BYTES + BYTES_PER_LED * MAX_LEDS
                                   + (MAX_LEDS + END_GROUP - 1) / END_GROUP;
    localparam int POS_W         = $clog2(MAX_TOTAL);

    localparam logic [BYTE_W-1:0] HDR_MARK   = 8'hE0;
    localparam logic [BYTE_W-1:0] END_BYTE   = 8'hFF;
    localparam logic [BYTE_W-1:0] START_BYTE = 8'h00;

    localparam logic [COUNT_W-1:0]  COUNT_RESET  = 9'd1;
    localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 5'd31;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = COUNT_W;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIP_LEN  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 1'd1;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_SET  = 2'd0,
        CMD_FILL = 2'd1,
        CMD_SHOW = 2'd2,
        CMD_PULL = 2'd3
    } t_cmd;

    // classified operation handed from the front to the back
    typedef struct packed {
        t_cmd                  cmd;
        logic [LED_AW-1:0]     index;
        logic [COLOUR_W-1:0]   colour;
        logic [COUNT_W-1:0]    count;
    } t_op;

endpackage

[hdl/srgb_cmd_if.sv]
interface srgb_cmd_if;
    logic                            valid;
    logic                            ready;
    logic [srgb_pkg::CMD_W-1:0]      command;
    logic [srgb_pkg::IDX_W-1:0]      led_index;
    logic [srgb_pkg::CHAN_W-1:0]     red;
    logic [srgb_pkg::CHAN_W-1:0]     green;
    logic [srgb_pkg::CHAN_W-1:0]     blue;

    modport source (output valid, command, led_index, red, green, blue, input ready);
    modport sink   (input valid, command, led_index, red, green, blue, output ready);
endinterface

[hdl/srgb_tx_if.sv]
interface srgb_tx_if;
    logic                            valid;
    logic                            ready;
    logic [srgb_pkg::BYTE_W-1:0]     tx_byte;
    logic                            last_byte;

    modport source (output valid, tx_byte, last_byte, input ready);
    modport sink   (input valid, tx_byte, last_byte, output ready);
endinterface

[hdl/srgb_front.sv]
module srgb_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [srgb_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [srgb_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    srgb_cmd_if.sink                          i_cmd,
    output srgb_pkg::t_op                     o_op,
    output logic                              o_op_valid,
    input  logic                              i_op_ready,
    output logic [srgb_pkg::BRIGHT_W-1:0]     o_brightness
);

    logic [srgb_pkg::COUNT_W-1:0]  r_eff_count;
    logic [srgb_pkg::BRIGHT_W-1:0] r_brightness;
    logic                          drop;

    // count is clamped when written so the accept path only compares
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff_count  <= srgb_pkg::COUNT_RESET;
            r_brightness <= srgb_pkg::BRIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                srgb_pkg::CFG_STRIP_LEN: begin
                    if (i_cfg_data == '0)
                        r_eff_count <= srgb_pkg::COUNT_W'(1);
                    else if (i_cfg_data > srgb_pkg::COUNT_W'(srgb_pkg::MAX_LEDS))
                        r_eff_count <= srgb_pkg::COUNT_W'(srgb_pkg::MAX_LEDS);
                    else
                        r_eff_count <= i_cfg_data;
                end
                srgb_pkg::CFG_BRIGHTNESS: begin
                    r_brightness <= i_cfg_data[srgb_pkg::BRIGHT_W-1:0];
                end
            endcase
        end
    end

    // a set beyond the strip is taken and dropped here
    assign drop = (srgb_pkg::t_cmd'(i_cmd.command) == srgb_pkg::CMD_SET)
                  && !(srgb_pkg::COUNT_W'(i_cmd.led_index) < r_eff_count);

    assign i_cmd.ready  = i_op_ready;
    assign o_op_valid   = i_cmd.valid && !drop;
    assign o_op.cmd     = srgb_pkg::t_cmd'(i_cmd.command);
    assign o_op.index   = srgb_pkg::LED_AW'(i_cmd.led_index);
    assign o_op.colour  = {i_cmd.red, i_cmd.green, i_cmd.blue};
    assign o_op.count   = r_eff_count;
    assign o_brightness = r_brightness;

endmodule

[hdl/srgb_op_fifo.sv]
module srgb_op_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  srgb_pkg::t_op  i_op,
    input  logic           i_op_valid,
    output logic           o_op_ready,
    output srgb_pkg::t_op  o_op,
    output logic           o_op_valid,
    input  logic           i_op_ready
);

    srgb_pkg::t_op                 r_entry [srgb_pkg::FIFO_DEPTH];
    logic [srgb_pkg::FIFO_AW-1:0]  r_wr_ptr;
    logic [srgb_pkg::FIFO_AW-1:0]  r_rd_ptr;
    logic [srgb_pkg::FIFO_AW:0]    r_count;
    logic                          push;
    logic                          pop;

    assign o_op_ready = (r_count != (srgb_pkg::FIFO_AW + 1)'(srgb_pkg::FIFO_DEPTH));
    assign o_op_valid = (r_count != '0);
    assign o_op       = r_entry[r_rd_ptr];
    assign push       = i_op_valid && o_op_ready;
    assign pop        = o_op_valid && i_op_ready;

    always_ff @(posedge i_clk) begin
        if (push)
            r_entry[r_wr_ptr] <= i_op;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push)
                r_wr_ptr <= (r_wr_ptr == srgb_pkg::FIFO_AW'(srgb_pkg::FIFO_DEPTH - 1))
                            ? '0 : r_wr_ptr + srgb_pkg::FIFO_AW'(1);
            if (pop)
                r_rd_ptr <= (r_rd_ptr == srgb_pkg::FIFO_AW'(srgb_pkg::FIFO_DEPTH - 1))
                            ? '0 : r_rd_ptr + srgb_pkg::FIFO_AW'(1);
            if (push && !pop)
                r_count <= r_count + (srgb_pkg::FIFO_AW + 1)'(1);
            else if (pop && !push)
                r_count <= r_count - (srgb_pkg::FIFO_AW + 1)'(1);
        end
    end

endmodule

[hdl/srgb_back.sv]
module srgb_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  srgb_pkg::t_op                     i_op,
    input  logic                              i_op_valid,
    output logic                              o_op_ready,
    input  logic [srgb_pkg::BRIGHT_W-1:0]     i_brightness,
    srgb_tx_if.source                         o_tx
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FILL,
        S_READ
    } t_state;

    localparam logic [1:0] SEL_HDR   = 2'd0;
    localparam logic [1:0] SEL_BLUE  = 2'd1;
    localparam logic [1:0] SEL_GREEN = 2'd2;
    localparam logic [1:0] SEL_RED   = 2'd3;

    localparam int PW = srgb_pkg::POS_W;
    localparam int AW = srgb_pkg::LED_AW;
    localparam int CW = srgb_pkg::COUNT_W;

    t_state                              r_state;
    logic                                r_active;
    logic [PW-1:0]                       r_pos;
    logic [PW-1:0]                       r_body_end;
    logic [PW-1:0]                       r_last_pos;
    logic [AW-1:0]                       r_fill_idx;
    logic [AW-1:0]                       r_fill_last;
    logic [srgb_pkg::COLOUR_W-1:0]       r_fill_colour;
    logic [1:0]                          r_sel;
    logic                                r_out_valid;
    logic [srgb_pkg::BYTE_W-1:0]         r_tx_byte;
    logic                                r_last_byte;

    logic [srgb_pkg::COLOUR_W-1:0]       r_colours [srgb_pkg::MAX_LEDS];
    logic [srgb_pkg::MAX_LEDS-1:0]       r_valid;
    logic [srgb_pkg::COLOUR_W-1:0]       r_rd_data;
    logic                                r_rd_valid;

    logic                                out_free;
    logic                                is_pull;
    logic                                pop;
    logic                                in_start;
    logic                                in_body;
    logic                                is_last;
    logic [PW-1:0]                       q;
    logic [1:0]                          sel;
    logic [AW-1:0]                       led;
    logic                                need_read;
    logic                                load_out;
    logic [srgb_pkg::BYTE_W-1:0]         direct_byte;
    logic [srgb_pkg::BYTE_W-1:0]         read_byte;
    logic [srgb_pkg::COLOUR_W-1:0]       rd_colour;
    logic                                mem_we;
    logic [AW-1:0]                       mem_waddr;
    logic [srgb_pkg::COLOUR_W-1:0]       mem_wdata;
    logic                                rd_en;
    logic [CW:0]                         ends_sum;
    logic [CW:0]                         ends;
    logic [PW-1:0]                       body_end;

    assign out_free   = !r_out_valid || o_tx.ready;
    assign is_pull    = (i_op.cmd == srgb_pkg::CMD_PULL);
    assign pop        = (r_state == S_IDLE) && i_op_valid && (!is_pull || out_free);
    assign o_op_ready = pop;

    // where the current position falls in the frame
    assign in_start  = (r_pos < PW'(srgb_pkg::START_BYTES));
    assign in_body   = !in_start && (r_pos < r_body_end);
    assign is_last   = !in_start && !in_body && (r_pos >= r_last_pos);
    assign q         = r_pos - PW'(srgb_pkg::START_BYTES);
    assign sel       = q[1:0];
    assign led       = q[AW+1:2];
    assign need_read = in_body && (sel != SEL_HDR);

    // the output register is loaded by a direct pull or by the end of a store read
    assign load_out  = (r_state == S_READ) || (pop && is_pull && r_active && !need_read);

    always_comb begin
        if (in_start)
            direct_byte = srgb_pkg::START_BYTE;
        else if (in_body)
            direct_byte = srgb_pkg::HDR_MARK | srgb_pkg::BYTE_W'(i_brightness);
        else
            direct_byte = srgb_pkg::END_BYTE;
    end

    // never-written entries read as black
    assign rd_colour = r_rd_valid ? r_rd_data : '0;

    always_comb begin
        unique case (r_sel)
            SEL_HDR:   read_byte = '0;
            SEL_BLUE:  read_byte = rd_colour[srgb_pkg::CHAN_W-1:0];
            SEL_GREEN: read_byte = rd_colour[2*srgb_pkg::CHAN_W-1:srgb_pkg::CHAN_W];
            SEL_RED:   read_byte = rd_colour[3*srgb_pkg::CHAN_W-1:2*srgb_pkg::CHAN_W];
        endcase
    end

    // single write port shared by set and the fill sweep
    assign mem_we    = (r_state == S_FILL) || (pop && (i_op.cmd == srgb_pkg::CMD_SET));
    assign mem_waddr = (r_state == S_FILL) ? r_fill_idx : i_op.index;
    assign mem_wdata = (r_state == S_FILL) ? r_fill_colour : i_op.colour;
    assign rd_en     = pop && is_pull && r_active && need_read;

    assign ends_sum  = {1'b0, i_op.count} + (CW + 1)'(srgb_pkg::END_GROUP - 1);
    assign ends      = ends_sum >> srgb_pkg::END_SHIFT;
    assign body_end  = PW'(srgb_pkg::START_BYTES) + (PW'(i_op.count) << 2);

    always_ff @(posedge i_clk) begin
        if (mem_we)
            r_colours[mem_waddr] <= mem_wdata;
        if (rd_en) begin
            r_rd_data  <= r_colours[led];
            r_rd_valid <= r_valid[led];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_valid <= '0;
        else if (mem_we)
            r_valid[mem_waddr] <= 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= 1'b0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load_out)
                r_out_valid <= 1'b1;
            else if (o_tx.ready)
                r_out_valid <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (pop) begin
                        unique case (i_op.cmd)
                            srgb_pkg::CMD_SET: begin
                            end
                            srgb_pkg::CMD_FILL: begin
                                r_fill_idx    <= '0;
                                r_fill_last   <= AW'(i_op.count - CW'(1));
                                r_fill_colour <= i_op.colour;
                                r_state       <= S_FILL;
                            end
                            srgb_pkg::CMD_SHOW: begin
                                r_active   <= 1'b1;
                                r_pos      <= '0;
                                r_body_end <= body_end;
                                r_last_pos <= body_end + PW'(ends) - PW'(1);
                            end
                            srgb_pkg::CMD_PULL: begin
                                if (r_active) begin
                                    if (is_last) begin
                                        r_active <= 1'b0;
                                        r_pos    <= '0;
                                    end else begin
                                        r_pos <= r_pos + PW'(1);
                                    end
                                    if (need_read) begin
                                        r_sel   <= sel;
                                        r_state <= S_READ;
                                    end else begin
                                        r_tx_byte   <= direct_byte;
                                        r_last_byte <= is_last;
                                    end
                                end
                            end
                        endcase
                    end
                end
                S_FILL: begin
                    if (r_fill_idx == r_fill_last)
                        r_state <= S_IDLE;
                    else
                        r_fill_idx <= r_fill_idx + AW'(1);
                end
                S_READ: begin
                    // output slot was freed when this pull was taken
                    r_tx_byte   <= read_byte;
                    r_last_byte <= 1'b0;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_tx.valid     = r_out_valid;
    assign o_tx.tx_byte   = r_tx_byte;
    assign o_tx.last_byte = r_last_byte;

endmodule

[hdl/serial_rgb_led_strip_frame_engine.sv]
// channel   dir  transfer when        payload
// i_cmd     in   valid & ready        command, led_index, red, green, blue
// o_tx      out  valid & ready        tx_byte, last_byte
// cfg       in   i_cfg_we             i_cfg_idx, i_cfg_data (no handshake)
//
// a pull of a start, header or end byte loads the output register directly; a pull of a
// colour byte goes first through the registered read of the colour store
// set and show complete when taken; fill sweeps the store, one store entry a cycle
// synchronous reset; the store is cleared at once through per-entry valid bits
// a two-entry queue sits between command intake and execution; results wait
// in an output register, and i_cmd stalls only when the queue is full
module serial_rgb_led_strip_frame_engine (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [srgb_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [srgb_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    srgb_cmd_if.sink                          i_cmd,
    srgb_tx_if.source                         o_tx
);

    srgb_pkg::t_op                  front_op;
    logic                           front_valid;
    logic                           front_ready;
    srgb_pkg::t_op                  back_op;
    logic                           back_valid;
    logic                           back_ready;
    logic [srgb_pkg::BRIGHT_W-1:0]  brightness;

    srgb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (i_cmd),
        .o_op         (front_op),
        .o_op_valid   (front_valid),
        .i_op_ready   (front_ready),
        .o_brightness (brightness)
    );

    srgb_op_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (front_op),
        .i_op_valid (front_valid),
        .o_op_ready (front_ready),
        .o_op       (back_op),
        .o_op_valid (back_valid),
        .i_op_ready (back_ready)
    );

    srgb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (back_op),
        .i_op_valid   (back_valid),
        .o_op_ready   (back_ready),
        .i_brightness (brightness),
        .o_tx         (o_tx)
    );

endmodule

[hdl/srgb_checker.sv]
`include "serial_rgb_led_strip_frame_engine_macros.svh"

module srgb_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_tx_valid,
    input  logic                           i_tx_ready,
    input  logic [srgb_pkg::BYTE_W-1:0]    i_tx_byte,
    input  logic                           i_last_byte
);

    `SRGB_ASSERT(a_idle_after_reset, i_clk, i_rst_n, $rose(i_rst_n) |-> !i_tx_valid, "result after reset")

    `SRGB_ASSERT(a_last_is_end, i_clk, i_rst_n, (i_tx_valid && i_last_byte) |-> (i_tx_byte == srgb_pkg::END_BYTE), "last byte is not an end byte")

    `SRGB_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, i_tx_valid && !i_tx_ready, i_tx_valid && $stable(i_tx_byte) && $stable(i_last_byte), "stalled result changed")

endmodule

bind serial_rgb_led_strip_frame_engine srgb_checker u_srgb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_tx_valid  (o_tx.valid),
    .i_tx_ready  (o_tx.ready),
    .i_tx_byte   (o_tx.tx_byte),
    .i_last_byte (o_tx.last_byte)
);

[verif/tb_serial_rgb_led_strip_frame_engine.sv]
module tb_serial_rgb_led_strip_frame_engine;
    timeunit 1ns;
    timeprecision 1ps;

    import srgb_pkg::*;

    localparam int CYCLE_LIMIT   = 3_000_000;
    // whole-store fills in the back end and in every queue entry
    localparam int SETTLE_CYCLES = 3 * (MAX_LEDS + 2) + 16;
    localparam int RANDOM_ITEMS  = 700;

    typedef struct {
        logic [BYTE_W-1:0] value;
        logic              is_last;
    } t_strip_byte;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    srgb_cmd_if cmd_bus ();
    srgb_tx_if  tx_bus ();

    serial_rgb_led_strip_frame_engine u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd_bus),
        .o_tx       (tx_bus)
    );

    // shadow of the strip state
    logic [COLOUR_W-1:0] strip_colours [MAX_LEDS];
    logic [COUNT_W-1:0]  cfg_strip_len;
    logic [BRIGHT_W-1:0] cfg_brightness;
    int                  show_leds;
    int                  show_pos;
    bit                  show_on;

    t_strip_byte frame_bytes_due [$];
    int          failures;
    int          useful_items;
    int unsigned cycles_run;
    bit          cmd_quiet;
    bit          tx_quiet;
    int          tx_stall_left;

    always begin
        #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles_run <= cycles_run + 1;
    end

    initial begin
        cycles_run = 0;
        wait (cycles_run >= CYCLE_LIMIT);
        $display("tb: failure");
        $finish;
    end

    function automatic int pick_gap(bit quiet);
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic int live_count();
        if (cfg_strip_len == 0) return 1;
        if (cfg_strip_len > MAX_LEDS) return MAX_LEDS;
        return int'(cfg_strip_len);
    endfunction

    // receiver back-pressure
    always @(posedge i_clk) begin
        int gap;
        if (!i_rst_n) begin
            tx_bus.ready  <= 1'b0;
            tx_stall_left <= 0;
        end else if (tx_stall_left > 0) begin
            tx_bus.ready  <= 1'b0;
            tx_stall_left <= tx_stall_left - 1;
        end else begin
            gap = pick_gap(tx_quiet);
            if (gap == 0) begin
                tx_bus.ready <= 1'b1;
            end else begin
                tx_bus.ready  <= 1'b0;
                tx_stall_left <= gap - 1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_strip_byte want;
        if (i_rst_n && tx_bus.valid && tx_bus.ready) begin
            if (frame_bytes_due.size() == 0) begin
                $display("%0t: unexpected transfer: expected none, got byte %02h last %0b",
                         $time, tx_bus.tx_byte, tx_bus.last_byte);
                failures++;
            end else begin
                want = frame_bytes_due.pop_front();
                if (tx_bus.tx_byte !== want.value) begin
                    $display("%0t: tx_byte expected %02h, got %02h",
                             $time, want.value, tx_bus.tx_byte);
                    failures++;
                end
                if (tx_bus.last_byte !== want.is_last) begin
                    $display("%0t: last_byte expected %0b, got %0b",
                             $time, want.is_last, tx_bus.last_byte);
                    failures++;
                end
            end
        end
    end

    task automatic apply_strip_command(t_cmd op, logic [IDX_W-1:0] idx,
                                       logic [COLOUR_W-1:0] rgb);
        int          n;
        int          k;
        int          q;
        int          bytes_in_show;
        t_strip_byte b;
        n = live_count();
        case (op)
            CMD_SET: begin
                if (int'(idx) < n) begin
                    strip_colours[idx] = rgb;
                    useful_items++;
                end
            end
            CMD_FILL: begin
                for (k = 0; k < n; k++) strip_colours[k] = rgb;
                useful_items++;
            end
            CMD_SHOW: begin
                show_leds = n;
                show_pos  = 0;
                show_on   = 1'b1;
                useful_items++;
            end
            default: begin
                if (show_on) begin
                    bytes_in_show = START_BYTES + BYTES_PER_LED * show_leds
                                    + (show_leds + END_GROUP - 1) / END_GROUP;
                    b.is_last = 1'b0;
                    if (show_pos < START_BYTES) begin
                        b.value = START_BYTE;
                    end else if (show_pos - START_BYTES < BYTES_PER_LED * show_leds) begin
                        q = show_pos - START_BYTES;
                        case (q % BYTES_PER_LED)
                            0:       b.value = HDR_MARK | {3'b000, cfg_brightness};
                            1:       b.value = strip_colours[q / BYTES_PER_LED][7:0];
                            2:       b.value = strip_colours[q / BYTES_PER_LED][15:8];
                            default: b.value = strip_colours[q / BYTES_PER_LED][23:16];
                        endcase
                    end else begin
                        b.value   = END_BYTE;
                        b.is_last = (show_pos + 1 >= bytes_in_show);
                    end
                    if (b.is_last) begin
                        show_on  = 1'b0;
                        show_pos = 0;
                    end else begin
                        show_pos++;
                    end
                    frame_bytes_due.push_back(b);
                    useful_items++;
                end
            end
        endcase
    endtask

    // valid stays high across back-to-back transfers
    task automatic send_command(t_cmd op, logic [IDX_W-1:0] idx, logic [CHAN_W-1:0] r,
                                logic [CHAN_W-1:0] g, logic [CHAN_W-1:0] b);
        int gap;
        gap = pick_gap(cmd_quiet);
        if (gap > 0) begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_bus.valid     <= 1'b1;
        cmd_bus.command   <= op;
        cmd_bus.led_index <= idx;
        cmd_bus.red       <= r;
        cmd_bus.green     <= g;
        cmd_bus.blue      <= b;
        do @(posedge i_clk); while (!cmd_bus.ready);
        apply_strip_command(op, idx, {r, g, b});
    endtask

    task automatic send_set(int idx);
        send_command(CMD_SET, idx[IDX_W-1:0], CHAN_W'($urandom_range(0, 255)),
                     CHAN_W'($urandom_range(0, 255)), CHAN_W'($urandom_range(0, 255)));
    endtask

    task automatic send_filler(t_cmd op);
        send_command(op, IDX_W'($urandom_range(0, 255)), CHAN_W'($urandom_range(0, 255)),
                     CHAN_W'($urandom_range(0, 255)), CHAN_W'($urandom_range(0, 255)));
    endtask

    // only once the block has drained and gone quiet
    task automatic configure_strip(logic [COUNT_W-1:0] count, logic [CFG_DATA_W-1:0] bright_word);
        cmd_bus.valid <= 1'b0;
        while (frame_bytes_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_STRIP_LEN;
        i_cfg_data <= count;
        @(posedge i_clk);
        cfg_strip_len = count;
        i_cfg_idx  <= CFG_BRIGHTNESS;
        i_cfg_data <= bright_word;
        @(posedge i_clk);
        cfg_brightness = bright_word[BRIGHT_W-1:0];
        i_cfg_we <= 1'b0;
    endtask

    function automatic int pick_index(int n);
        if ($urandom_range(0, 99) < 85) return $urandom_range(0, n - 1);
        return $urandom_range(0, 255);
    endfunction

    function automatic logic [COUNT_W-1:0] pick_strip_len();
        int r;
        int corner;
        r = $urandom_range(0, 99);
        if (r < 55) return COUNT_W'($urandom_range(1, 12));
        if (r < 75) return COUNT_W'($urandom_range(13, 40));
        if (r < 87) begin
            corner = $urandom_range(0, 7);
            case (corner)
                0:       return COUNT_W'(0);
                1:       return COUNT_W'(1);
                2:       return COUNT_W'(15);
                3:       return COUNT_W'(16);
                4:       return COUNT_W'(17);
                5:       return COUNT_W'(33);
                6:       return COUNT_W'(256);
                default: return COUNT_W'(511);
            endcase
        end
        if (r < 94) return COUNT_W'($urandom_range(41, 255));
        return COUNT_W'($urandom_range(256, 511));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_bright_word();
        int r;
        logic [BRIGHT_W-1:0] v;
        r = $urandom_range(0, 99);
        if (r < 15)      v = '0;
        else if (r < 25) v = '1;
        else if (r < 30) v = BRIGHT_W'(1);
        else             v = BRIGHT_W'($urandom_range(0, 31));
        return {4'($urandom_range(0, 15)), v};
    endfunction

    task automatic test_reset_show();
        send_filler(CMD_PULL);
        send_filler(CMD_SHOW);
        repeat (9) send_filler(CMD_PULL);
        send_filler(CMD_PULL);
    endtask

    task automatic test_count_floor_dark_header();
        // count of zero acts as one LED, brightness zero leaves a bare header mark
        configure_strip(9'd0, {4'hF, 5'd0});
        send_command(CMD_SET, 8'd0, 8'hFF, 8'h00, 8'h80);
        send_command(CMD_SET, 8'd1, 8'h00, 8'hFF, 8'h7F);
        send_command(CMD_SET, 8'd255, 8'hAA, 8'h55, 8'hFF);
        send_filler(CMD_SHOW);
        repeat (9) send_filler(CMD_PULL);
    endtask

    task automatic test_full_strip();
        // over-range count clamps to the whole store; count and brightness
        // change mid-show, the show keeps its latched length and is left
        // running for the next show to restart
        configure_strip(9'd511, 9'h1FF);
        send_filler(CMD_FILL);
        send_set(255);
        send_set(0);
        send_filler(CMD_SHOW);
        repeat (48) send_filler(CMD_PULL);
        send_set(250);
        send_set(10);
        configure_strip(9'd3, {4'hA, 5'd5});
        repeat (40) send_filler(CMD_PULL);
    endtask

    task automatic run_strip_sequence();
        int n;
        int r;
        int budget;
        int steps;
        bit whole_show;
        n = live_count();
        repeat ($urandom_range(0, 4)) begin
            r = $urandom_range(0, 99);
            if (r < 65)      send_set(pick_index(n));
            else if (r < 80) send_filler(CMD_FILL);
            else             send_filler(t_cmd'($urandom_range(0, 3)));
        end
        send_filler(CMD_SHOW);
        whole_show = (n <= 64) && ($urandom_range(0, 9) < 7);
        budget = whole_show ? 4000 : $urandom_range(1, 30);
        steps = 0;
        while (show_on && steps < budget) begin
            r = $urandom_range(0, 99);
            if (r < 88)      send_filler(CMD_PULL);
            else if (r < 93) send_set(pick_index(show_leds));
            else if (r < 96) send_filler(CMD_FILL);
            else if (r < 98) send_filler(CMD_SHOW);
            else             send_filler(t_cmd'($urandom_range(0, 3)));
            steps++;
        end
        if (!show_on && $urandom_range(0, 4) == 0) send_filler(CMD_PULL);
    endtask

    task automatic test_random_traffic();
        int goal;
        goal = useful_items + RANDOM_ITEMS;
        while (useful_items < goal) begin
            configure_strip(pick_strip_len(), pick_bright_word());
            cmd_quiet = ($urandom_range(0, 4) == 0);
            tx_quiet  = ($urandom_range(0, 4) == 0);
            run_strip_sequence();
        end
    endtask

    initial begin
        int k;
        for (k = 0; k < MAX_LEDS; k++) strip_colours[k] = '0;
        cfg_strip_len  = COUNT_RESET;
        cfg_brightness = BRIGHT_RESET;
        show_leds      = 1;
        show_pos       = 0;
        show_on        = 1'b0;
        failures       = 0;
        useful_items   = 0;
        cmd_quiet      = 1'b0;
        tx_quiet       = 1'b0;

        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_idx         <= CFG_STRIP_LEN;
        i_cfg_data        <= '0;
        cmd_bus.valid     <= 1'b0;
        cmd_bus.command   <= CMD_SET;
        cmd_bus.led_index <= '0;
        cmd_bus.red       <= '0;
        cmd_bus.green     <= '0;
        cmd_bus.blue      <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_show();
        test_count_floor_dark_header();
        test_full_strip();
        test_random_traffic();

        cmd_bus.valid <= 1'b0;
        while (frame_bytes_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (failures == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
